[hw/rtl/pgt_pkg.sv]
// Shared types, codes and helpers for the per-peer sequence gap tracker.
package pgt_pkg;

  localparam int unsigned KEY_W   = 40;
  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned PEER_W  = 7;
  localparam int unsigned ENTRY_W = KEY_W + SEQ_W;

  typedef enum logic {
    OP_PACKET = 1'b0,
    OP_STATS  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_NEW      = 3'd0,
    ST_IN_ORDER = 3'd1,
    ST_GAP      = 3'd2,
    ST_DUP      = 3'd3,
    ST_FULL     = 3'd4,
    ST_STATS    = 3'd5
  } status_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_SCAN = 1'b1
  } back_state_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [SEQ_W-1:0] seq;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage

[hw/rtl/per_peer_sequence_gap_tracker_unit.sv]
// Top level of the per-peer sequence gap tracker: front end, queue and back end.
//
// Channel   Direction  Handshake                         Payload
// request   in         start / busy (taken: start&!busy) in_operation, in_node_id,
//                                                        in_interface_index,
//                                                        in_sequence_number
// result    out        out_valid, one cycle, no stall    out_status, out_total_dropped,
//                                                        out_period_dropped, out_peer_count
//
// A stats request is answered once the back end pops it from the queue. A packet request
// scans the peer table RAM one entry per cycle (registered read port) and stops at the
// matching entry; a new peer or a full table is reported once all filled entries are read.
// Requests ahead in the queue delay results. A two-entry queue decouples intake from
// the scan; busy is high while it is full. Reset (rst_n low, synchronous) empties the
// table and clears all counters; the receiver cannot stall results.
module per_peer_sequence_gap_tracker_unit #(
  parameter int unsigned PEER_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [31:0] in_node_id,
  input  logic [7:0]  in_interface_index,
  input  logic [31:0] in_sequence_number,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_total_dropped,
  output logic [31:0] out_period_dropped,
  output logic [6:0]  out_peer_count
);
  import pgt_pkg::*;

  queue_head_t head;
  logic        pop;

  pgt_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .in_op  (in_operation),
    .in_node(in_node_id),
    .in_ifx (in_interface_index),
    .in_seq (in_sequence_number),
    .head   (head),
    .pop    (pop)
  );

  pgt_back #(
    .PEER_ENTRIES(PEER_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_status(out_status),
    .out_total (out_total_dropped),
    .out_period(out_period_dropped),
    .out_peers (out_peer_count)
  );

endmodule

[hw/rtl/pgt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pgt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/pgt_front.sv]
// Front end: request intake, classification and a two-entry queue to the back end.
module pgt_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_op,
  input  logic [31:0]          in_node,
  input  logic [7:0]           in_ifx,
  input  logic [31:0]          in_seq,
  output pgt_pkg::queue_head_t head,
  input  logic                 pop
);
  import pgt_pkg::*;

  item_t      q_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  item_t      in_item;

  assign busy = (cnt_r == 2'd2);
  assign push = start && !busy;

  always_comb begin
    in_item.op  = in_op ? OP_STATS : OP_PACKET;
    in_item.key = {in_node, in_ifx};
    in_item.seq = in_seq;
  end

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= in_item;
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_r[rptr_r];

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> cnt_r != 2'd0)
    else $error("pop from empty queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
      (cnt_r == 2'd1) |-> (wptr_r != rptr_r))
    else $error("queue pointers disagree with count");
`endif

endmodule

[hw/rtl/pgt_back.sv]
// Back end: peer table scan, insert or sequence update, drop counters, result register.
module pgt_back #(
  parameter int unsigned PEER_ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pgt_pkg::queue_head_t head,
  output logic                 pop,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic [31:0]          out_total,
  output logic [31:0]          out_period,
  output logic [6:0]           out_peers
);
  import pgt_pkg::*;

  localparam int unsigned AW = $clog2(PEER_ENTRIES);
  localparam int unsigned CW = $clog2(PEER_ENTRIES + 1);

  back_state_t       state_r, state_nxt;
  item_t             cur_r, cur_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     paddr_r, paddr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [CNT_W-1:0]  period_r, period_nxt;
  logic              ov_r, ov_nxt;
  status_t           ost_r, ost_nxt;
  logic [CNT_W-1:0]  otot_r, otot_nxt;
  logic [CNT_W-1:0]  oper_r, oper_nxt;
  logic [PEER_W-1:0] opeer_r, opeer_nxt;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [AW-1:0]      raddr;
  logic [ENTRY_W-1:0] rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [SEQ_W-1:0]   rd_seq;
  logic [SEQ_W-1:0]   succ;
  logic               hit;
  logic [31:0]        count_ext;

  pgt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(PEER_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_key = rdata[ENTRY_W-1 -: KEY_W];
  assign rd_seq = rdata[SEQ_W-1:0];
  assign succ   = rd_seq + SEQ_W'(1);
  assign hit    = pend_r && (rd_key == cur_r.key);

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    idx_nxt    = idx_r;
    pend_nxt   = 1'b0;
    paddr_nxt  = paddr_r;
    count_nxt  = count_r;
    total_nxt  = total_r;
    period_nxt = period_r;
    ov_nxt     = 1'b0;
    ost_nxt    = ost_r;
    pop        = 1'b0;
    we         = 1'b0;
    waddr      = paddr_r;
    wdata      = {cur_r.key, cur_r.seq};
    raddr      = idx_r[AW-1:0];

    unique case (state_r)
      BK_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.item.op == OP_STATS) begin
            ov_nxt     = 1'b1;
            ost_nxt    = ST_STATS;
            period_nxt = '0;
          end else begin
            cur_nxt   = head.item;
            idx_nxt   = '0;
            state_nxt = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        if (hit) begin
          we     = 1'b1;
          waddr  = paddr_r;
          ov_nxt = 1'b1;
          if (cur_r.seq > succ) begin
            total_nxt  = sat_inc(total_r);
            period_nxt = sat_inc(period_r);
            ost_nxt    = ST_GAP;
          end else if (cur_r.seq <= rd_seq) begin
            ost_nxt = ST_DUP;
          end else begin
            ost_nxt = ST_IN_ORDER;
          end
          state_nxt = BK_IDLE;
        end else if (idx_r < count_r) begin
          pend_nxt  = 1'b1;
          paddr_nxt = idx_r[AW-1:0];
          idx_nxt   = idx_r + CW'(1);
        end else begin
          ov_nxt = 1'b1;
          if (count_r == CW'(PEER_ENTRIES)) begin
            ost_nxt = ST_FULL;
          end else begin
            we        = 1'b1;
            waddr     = count_r[AW-1:0];
            count_nxt = count_r + CW'(1);
            ost_nxt   = ST_NEW;
          end
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase

    count_ext = 32'(count_nxt);
    otot_nxt  = total_nxt;
    oper_nxt  = (state_r == BK_IDLE) ? period_r : period_nxt;
    opeer_nxt = (count_ext > 32'd127) ? 7'd127 : count_ext[PEER_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      pend_r   <= 1'b0;
      idx_r    <= '0;
      count_r  <= '0;
      total_r  <= '0;
      period_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_r   <= pend_nxt;
      idx_r    <= idx_nxt;
      count_r  <= count_nxt;
      total_r  <= total_nxt;
      period_r <= period_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    paddr_r <= paddr_nxt;
    ost_r   <= ost_nxt;
    otot_r  <= otot_nxt;
    oper_r  <= oper_nxt;
    opeer_r <= opeer_nxt;
  end

  assign out_valid  = ov_r;
  assign out_status = ost_r;
  assign out_total  = otot_r;
  assign out_period = oper_r;
  assign out_peers  = opeer_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
      count_r <= CW'(PEER_ENTRIES))
    else $error("peer count above table size");
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == BK_SCAN) |-> (idx_r <= count_r))
    else $error("scan index past filled entries");
  a_stats_clear: assert property (@(posedge clk) disable iff (!rst_n)
      (ov_r && ost_r == ST_STATS) |-> (period_r == '0))
    else $error("period counter not cleared by stats request");
  a_gap_total: assert property (@(posedge clk) disable iff (!rst_n)
      (ov_r && ost_r == ST_GAP) |-> (total_r != '0))
    else $error("gap reported without total drop count");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == BK_SCAN && state_nxt == BK_IDLE) |=> ov_r)
    else $error("scan finished without result");
`endif

endmodule
